/* rtl/alle_pkg.sv */
// Shared types and constants for the array linked list engine.
// No dependencies; alle_ctrl, alle_dp and the top file refer to this package by scoped names.
`default_nettype none
package alle_pkg;

    localparam int SLOT_COUNT_DEF = 256;

    localparam logic [2:0] CMD_APPEND    = 3'd0;
    localparam logic [2:0] CMD_INSERT    = 3'd1;
    localparam logic [2:0] CMD_REMOVE_AT = 3'd2;
    localparam logic [2:0] CMD_REMOVE_VAL = 3'd3;
    localparam logic [2:0] CMD_FIND      = 3'd4;
    localparam logic [2:0] CMD_READ      = 3'd5;
    localparam logic [2:0] CMD_CLEAR     = 3'd6;
    localparam logic [2:0] CMD_UNUSED    = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic [2:0]         command;
        logic [8:0]         position;
        logic signed [31:0] value;
    } t_cmd_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         found_position;
        logic signed [31:0] read_value;
        logic [8:0]         list_size;
    } t_result;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECIDE, S_SCAN0, S_SCAN, S_WALK0, S_WALK,
        S_UNLINK, S_INS_B, S_INS_A, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_HOLD, OP_LOAD, OP_CLR, OP_SCAN0, OP_SCAN, OP_WALK0, OP_STEP,
        OP_UNLINK, OP_INS_B, OP_INS_A, OP_DONE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] status;
    } t_dp_ctl;

    typedef struct packed {
        logic [2:0] cmd;
        logic       count_zero;
        logic       count_full;
        logic       pos_gt;
        logic       pos_ge;
        logic       used_rd;
        logic       walk_stop;
        logic       walk_end;
        logic       clr_last;
    } t_dp_stat;

endpackage
`default_nettype wire

/* rtl/alle_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module alle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/alle_ctrl.sv */
// Command sequencer for the linked list engine: decides the micro-step order per command.
// Depends on alle_pkg; drives alle_dp through t_dp_ctl and reads t_dp_stat.
`default_nettype none
module alle_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire alle_pkg::t_dp_stat  i_stat,
    output logic                     busy,
    output alle_pkg::t_dp_ctl        o_ctl
);
    alle_pkg::t_state r_state, n_state;
    logic [2:0]       r_status, n_status;
    logic             r_reply, n_reply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= alle_pkg::S_CLEAR;
            r_status <= alle_pkg::ST_OK;
            r_reply  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_reply  <= n_reply;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_reply      = r_reply;
        o_ctl.op     = alle_pkg::OP_HOLD;
        o_ctl.status = r_status;
        busy         = (r_state != alle_pkg::S_IDLE);
        unique case (r_state)
            alle_pkg::S_CLEAR: begin
                o_ctl.op = alle_pkg::OP_CLR;
                if (i_stat.clr_last) begin
                    n_status = alle_pkg::ST_OK;
                    n_state  = r_reply ? alle_pkg::S_DONE : alle_pkg::S_IDLE;
                end
            end
            alle_pkg::S_IDLE: begin
                if (start) begin
                    o_ctl.op = alle_pkg::OP_LOAD;
                    n_state  = alle_pkg::S_DECIDE;
                end
            end
            alle_pkg::S_DECIDE: begin
                n_status = alle_pkg::ST_OK;
                n_state  = alle_pkg::S_DONE;
                unique case (i_stat.cmd) inside
                    alle_pkg::CMD_APPEND, alle_pkg::CMD_INSERT: begin
                        if (i_stat.pos_gt) begin
                            n_status = alle_pkg::ST_RANGE;
                        end else if (i_stat.count_full) begin
                            n_status = alle_pkg::ST_FULL;
                        end else begin
                            n_state = alle_pkg::S_SCAN0;
                        end
                    end
                    alle_pkg::CMD_REMOVE_AT, alle_pkg::CMD_READ: begin
                        if (i_stat.count_zero) begin
                            n_status = alle_pkg::ST_EMPTY;
                        end else if (i_stat.pos_ge) begin
                            n_status = alle_pkg::ST_RANGE;
                        end else begin
                            n_state = alle_pkg::S_WALK0;
                        end
                    end
                    alle_pkg::CMD_REMOVE_VAL, alle_pkg::CMD_FIND: begin
                        if (i_stat.count_zero) begin
                            n_status = alle_pkg::ST_EMPTY;
                        end else begin
                            n_state = alle_pkg::S_WALK0;
                        end
                    end
                    alle_pkg::CMD_CLEAR: begin
                        n_reply = 1'b1;
                        n_state = alle_pkg::S_CLEAR;
                    end
                    default: ;
                endcase
            end
            alle_pkg::S_SCAN0: begin
                o_ctl.op = alle_pkg::OP_SCAN0;
                n_state  = alle_pkg::S_SCAN;
            end
            alle_pkg::S_SCAN: begin
                o_ctl.op = alle_pkg::OP_SCAN;
                if (!i_stat.used_rd) begin
                    // middle insert needs the predecessor found by a walk
                    if (!i_stat.count_zero && !i_stat.pos_ge
                            && i_stat.cmd == alle_pkg::CMD_INSERT) begin
                        n_state = alle_pkg::S_WALK0;
                    end else begin
                        n_state = alle_pkg::S_INS_B;
                    end
                end
            end
            alle_pkg::S_WALK0: begin
                o_ctl.op = alle_pkg::OP_WALK0;
                n_state  = alle_pkg::S_WALK;
            end
            alle_pkg::S_WALK: begin
                if (!i_stat.walk_stop) begin
                    o_ctl.op = alle_pkg::OP_STEP;
                end else begin
                    n_status = alle_pkg::ST_OK;
                    n_state  = alle_pkg::S_DONE;
                    unique case (i_stat.cmd) inside
                        alle_pkg::CMD_INSERT:    n_state = alle_pkg::S_INS_B;
                        alle_pkg::CMD_REMOVE_AT: n_state = alle_pkg::S_UNLINK;
                        alle_pkg::CMD_REMOVE_VAL: begin
                            if (i_stat.walk_end) begin
                                n_status = alle_pkg::ST_NOT_FOUND;
                            end else begin
                                n_state = alle_pkg::S_UNLINK;
                            end
                        end
                        alle_pkg::CMD_FIND: begin
                            if (i_stat.walk_end) begin
                                n_status = alle_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            alle_pkg::S_UNLINK: begin
                o_ctl.op = alle_pkg::OP_UNLINK;
                n_state  = alle_pkg::S_DONE;
            end
            alle_pkg::S_INS_B: begin
                o_ctl.op = alle_pkg::OP_INS_B;
                n_state  = alle_pkg::S_INS_A;
            end
            alle_pkg::S_INS_A: begin
                o_ctl.op = alle_pkg::OP_INS_A;
                n_status = alle_pkg::ST_OK;
                n_state  = alle_pkg::S_DONE;
            end
            alle_pkg::S_DONE: begin
                o_ctl.op = alle_pkg::OP_DONE;
                n_reply  = 1'b0;
                n_state  = alle_pkg::S_IDLE;
            end
            default: n_state = alle_pkg::S_IDLE;
        endcase
    end

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == alle_pkg::S_DONE) |=> (r_state == alle_pkg::S_IDLE))
        else $error("done state not followed by idle");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == alle_pkg::S_DECIDE))
        else $error("accepted beat not decoded");
endmodule
`default_nettype wire

/* rtl/alle_dp.sv */
// Datapath of the linked list engine: list registers, walk and free-slot scan, slot RAMs.
// Depends on alle_pkg and alle_ram; sequenced by alle_ctrl.
`default_nettype none
module alle_dp #(
    parameter int SLOT_COUNT = alle_pkg::SLOT_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire alle_pkg::t_cmd_in  i_cmd,
    input  wire alle_pkg::t_dp_ctl  i_ctl,
    output alle_pkg::t_dp_stat      o_stat,
    output logic                    o_done,
    output alle_pkg::t_result       o_result
);
    localparam int W    = $clog2(SLOT_COUNT);
    localparam int CW   = $clog2(SLOT_COUNT + 1);
    localparam int CMPW = (CW > 9) ? CW : 9;

    logic [2:0]        r_cmd;
    logic [CMPW-1:0]   r_pos;
    logic [31:0]       r_value;
    logic [W-1:0]      r_scan, r_head, r_tail, r_cur, r_prev;
    logic [CW-1:0]     r_count, r_idx;

    logic              link_we, val_we, used_we, used_wdata, used_rd;
    logic [W-1:0]      link_waddr, link_wdata, used_waddr, used_raddr, walk_raddr;
    logic [W-1:0]      link_rd;
    logic [31:0]       val_rd;

    logic count_zero, pos_ge, pos_zero, idx_zero, idx_last, walk_end, match, find_mode;

    assign count_zero = (r_count == '0);
    assign pos_ge     = (CMPW'(r_count) <= r_pos);
    assign pos_zero   = (r_pos == '0);
    assign idx_zero   = (r_idx == '0);
    assign idx_last   = (CW'(r_idx + 1'b1) == r_count);
    assign walk_end   = (r_idx == r_count);
    assign match      = (val_rd == r_value);
    assign find_mode  = (r_cmd == alle_pkg::CMD_REMOVE_VAL) || (r_cmd == alle_pkg::CMD_FIND);

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.count_zero = count_zero;
        o_stat.count_full = (r_count == CW'(SLOT_COUNT));
        o_stat.pos_gt     = (CMPW'(r_count) < r_pos);
        o_stat.pos_ge     = pos_ge;
        o_stat.used_rd    = used_rd;
        o_stat.walk_end   = walk_end;
        o_stat.walk_stop  = find_mode ? (walk_end || match) : (CMPW'(r_idx) == r_pos);
        o_stat.clr_last   = (r_scan == W'(SLOT_COUNT - 1));
    end

    // RAM ports; walk read address defaults to the cursor so read data holds
    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_scan;
        link_wdata = '0;
        val_we     = 1'b0;
        used_we    = 1'b0;
        used_waddr = r_scan;
        used_wdata = 1'b0;
        used_raddr = r_scan;
        walk_raddr = r_cur;
        unique case (i_ctl.op)
            alle_pkg::OP_CLR:   used_we = 1'b1;
            alle_pkg::OP_SCAN0: used_raddr = '0;
            alle_pkg::OP_SCAN:  used_raddr = used_rd ? W'(r_scan + 1'b1) : r_scan;
            alle_pkg::OP_WALK0: walk_raddr = r_head;
            alle_pkg::OP_STEP:  walk_raddr = link_rd;
            alle_pkg::OP_UNLINK: begin
                used_we    = 1'b1;
                used_waddr = r_cur;
                link_we    = !idx_zero;
                link_waddr = r_prev;
                link_wdata = link_rd;
            end
            alle_pkg::OP_INS_B: begin
                link_we    = !count_zero && (pos_ge || !pos_zero);
                link_waddr = pos_ge ? r_tail : r_prev;
                link_wdata = r_scan;
            end
            alle_pkg::OP_INS_A: begin
                val_we     = 1'b1;
                used_we    = 1'b1;
                used_wdata = 1'b1;
                link_we    = 1'b1;
                link_wdata = (count_zero || pos_ge) ? '0 : (pos_zero ? r_head : r_cur);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= (i_ctl.op == alle_pkg::OP_DONE);
            unique case (i_ctl.op)
                alle_pkg::OP_LOAD: begin
                    r_cmd   <= i_cmd.command;
                    r_pos   <= (i_cmd.command == alle_pkg::CMD_APPEND) ?
                               CMPW'(r_count) : CMPW'(i_cmd.position);
                    r_value <= i_cmd.value;
                    r_scan  <= '0;
                end
                alle_pkg::OP_CLR: begin
                    r_scan  <= W'(r_scan + 1'b1);
                    r_head  <= '0;
                    r_tail  <= '0;
                    r_count <= '0;
                end
                alle_pkg::OP_SCAN0: r_scan <= '0;
                alle_pkg::OP_SCAN: begin
                    if (used_rd) begin
                        r_scan <= W'(r_scan + 1'b1);
                    end
                end
                alle_pkg::OP_WALK0: begin
                    r_cur <= r_head;
                    r_idx <= '0;
                end
                alle_pkg::OP_STEP: begin
                    r_prev <= r_cur;
                    r_cur  <= link_rd;
                    r_idx  <= CW'(r_idx + 1'b1);
                end
                alle_pkg::OP_UNLINK: begin
                    r_count <= CW'(r_count - 1'b1);
                    if (r_count == CW'(1)) begin
                        r_head <= '0;
                        r_tail <= '0;
                    end else if (idx_zero) begin
                        r_head <= link_rd;
                    end else if (idx_last) begin
                        r_tail <= r_prev;
                    end
                end
                alle_pkg::OP_INS_A: begin
                    r_count <= CW'(r_count + 1'b1);
                    if (count_zero) begin
                        r_head <= r_scan;
                        r_tail <= r_scan;
                    end else if (pos_ge) begin
                        r_tail <= r_scan;
                    end else if (pos_zero) begin
                        r_head <= r_scan;
                    end
                end
                alle_pkg::OP_DONE: begin
                    o_result.status         <= i_ctl.status;
                    o_result.found_position <= (i_ctl.status == alle_pkg::ST_OK && find_mode) ?
                                               8'(r_idx) : 8'd0;
                    o_result.read_value     <= (i_ctl.status == alle_pkg::ST_OK &&
                                                r_cmd == alle_pkg::CMD_READ) ? val_rd : 32'd0;
                    o_result.list_size      <= 9'(r_count);
                end
                default: ;
            endcase
        end
    end

    alle_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_values (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(r_scan), .i_wdata(r_value),
        .i_raddr(walk_raddr), .o_rdata(val_rd)
    );
    alle_ram #(.WIDTH(W), .DEPTH(SLOT_COUNT)) u_links (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr), .i_wdata(link_wdata),
        .i_raddr(walk_raddr), .o_rdata(link_rd)
    );
    alle_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_used (
        .i_clk(i_clk), .i_we(used_we), .i_waddr(used_waddr), .i_wdata(used_wdata),
        .i_raddr(used_raddr), .o_rdata(used_rd)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOT_COUNT))
        else $error("entry count above store size");
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == '0 && r_tail == '0))
        else $error("empty list with nonzero head or tail");
endmodule
`default_nettype wire

/* rtl/array_linked_list_engine_top.sv */
// Array linked list engine: a singly linked list held in a slot store of SLOT_COUNT entries.
// One command is taken per start beat while busy is low and answered by one result
// beat on o_done, which the receiver takes in that cycle. After reset, and for a clear
// command, the used-slot store is swept with busy high. Append and insert scan used bits
// one slot per cycle up to the lowest free slot, position commands walk one link per cycle
// from the head, and find and remove value walk until the match or list end. The longest
// command is a middle insert, which scans and then walks; the walk rate is set by the
// registered read of the link RAM fed straight back as the next address.
// Depends on alle_pkg, alle_ctrl, alle_dp and alle_ram.
`default_nettype none
module array_linked_list_engine_top #(
    parameter int SLOT_COUNT = alle_pkg::SLOT_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire alle_pkg::t_cmd_in  i_cmd,
    output logic                    busy,
    output logic                    o_done,
    output alle_pkg::t_result       o_result
);
    alle_pkg::t_dp_ctl  ctl;
    alle_pkg::t_dp_stat stat;

    alle_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_stat(stat),
        .busy(busy), .o_ctl(ctl)
    );

    alle_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd), .i_ctl(ctl),
        .o_stat(stat), .o_done(o_done), .o_result(o_result)
    );

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result beat without a command in flight");
endmodule
`default_nettype wire
